@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL. Define ASSERT_OFF to drop
// them from a build.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/brrc_pkg.sv @@
// ----------------------------------------------------------------------------
// brrc_pkg
// Types, sizes and codes shared by the banker's resource request checker.
// ----------------------------------------------------------------------------
package brrc_pkg;

  // storage sizes
  localparam int MAX_PROCS = 8;
  localparam int MAX_RES   = 4;

  // field and register widths
  localparam int PROC_W     = 3;
  localparam int RES_W      = 2;
  localparam int AMT_W      = 8;
  localparam int WORK_W     = 11;
  localparam int NP_W       = 4;
  localparam int NR_W       = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [WORK_W-1:0] WORK_MAX = {WORK_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROCS     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESOURCES = 1'b1;

  typedef enum logic [1:0] {
    FUNC_LD_FREE  = 2'd0,
    FUNC_LD_CLAIM = 2'd1,
    FUNC_LD_HELD  = 2'd2,
    FUNC_REQ      = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    VERDICT_GRANTED  = 3'd0,
    VERDICT_NEED     = 3'd1,
    VERDICT_FREE     = 3'd2,
    VERDICT_UNSAFE   = 3'd3,
    VERDICT_BAD_PROC = 3'd4
  } verdict_t;

  typedef struct packed {
    func_t              func;
    logic [PROC_W-1:0]  process;
    logic [RES_W-1:0]   resource;
    logic [AMT_W-1:0]   amount;
    logic               last;
  } request_t;

  typedef struct packed {
    logic [PROC_W-1:0] requester;
    verdict_t          verdict;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_RD,
    ST_CHK,
    ST_SCAN_START,
    ST_SCAN,
    ST_FINISH
  } ctl_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LD_FREE,
    OP_LD_CLAIM,
    OP_LD_HELD,
    OP_LD_REQ,
    OP_CHECK,
    OP_SCAN_ROW,
    OP_FINISH
  } dp_op_t;

  typedef logic [MAX_RES-1:0][AMT_W-1:0] row_t;

  typedef struct packed {
    dp_op_t            op;
    logic [PROC_W-1:0] rd_row;
    logic [PROC_W-1:0] scan_row;
    logic [PROC_W-1:0] req_proc;
  } dp_cmd_t;

  typedef struct packed {
    logic alloc_ok;
    logic row_ok;
  } dp_stat_t;

endpackage

@@ rtl/brrc_datapath.sv @@
// ----------------------------------------------------------------------------
// brrc_datapath
// Free units, request buffer, claim and held tables, safety scan work
// vector and finished flags, with the compare and update logic per command.
// ----------------------------------------------------------------------------
module brrc_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  brrc_pkg::dp_cmd_t          cmd,
  input  brrc_pkg::request_t         request,
  input  logic [brrc_pkg::NP_W-1:0]  np,
  input  logic [brrc_pkg::NR_W-1:0]  nr,
  output brrc_pkg::dp_stat_t         stat,
  output brrc_pkg::result_t          result,
  output logic                       result_valid
);

  logic [brrc_pkg::AMT_W-1:0]  free_units [brrc_pkg::MAX_RES];
  logic [brrc_pkg::AMT_W-1:0]  req_buf    [brrc_pkg::MAX_RES];
  logic [brrc_pkg::WORK_W-1:0] work       [brrc_pkg::MAX_RES];
  logic [brrc_pkg::MAX_PROCS-1:0] finished;

  // row-wide tables, one lane per resource
  brrc_pkg::row_t claim_mem [brrc_pkg::MAX_PROCS];
  brrc_pkg::row_t held_mem  [brrc_pkg::MAX_PROCS];
  logic [brrc_pkg::MAX_RES-1:0] claim_vld [brrc_pkg::MAX_PROCS];
  logic [brrc_pkg::MAX_RES-1:0] held_vld  [brrc_pkg::MAX_PROCS];
  brrc_pkg::row_t claim_q;
  brrc_pkg::row_t held_q;
  logic [brrc_pkg::MAX_RES-1:0] claim_vq;
  logic [brrc_pkg::MAX_RES-1:0] held_vq;
  brrc_pkg::row_t saved_row;

  brrc_pkg::row_t claim_row;
  brrc_pkg::row_t held_row;
  logic [brrc_pkg::MAX_RES-1:0]   res_mask;
  logic [brrc_pkg::MAX_PROCS-1:0] proc_mask;
  logic [brrc_pkg::MAX_RES-1:0]   need_over;
  logic [brrc_pkg::MAX_RES-1:0]   free_over;
  logic [brrc_pkg::MAX_RES-1:0]   fit;
  logic [brrc_pkg::WORK_W:0]      work_sum [brrc_pkg::MAX_RES];
  logic [brrc_pkg::WORK_W-1:0]    work_sat [brrc_pkg::MAX_RES];
  logic bad_proc;
  logic need_fail;
  logic free_fail;
  logic alloc_ok;
  logic row_ok;
  logic safe;
  brrc_pkg::verdict_t chk_verdict;

  logic [brrc_pkg::PROC_W-1:0]  held_waddr;
  logic [brrc_pkg::MAX_RES-1:0] held_we;
  brrc_pkg::row_t               held_wdata;

  // mask active lanes and rows
  always_comb begin
    for (int j = 0; j < brrc_pkg::MAX_RES; j++) begin
      res_mask[j] = brrc_pkg::NR_W'(j) < nr;
    end
    for (int i = 0; i < brrc_pkg::MAX_PROCS; i++) begin
      proc_mask[i] = brrc_pkg::NP_W'(i) < np;
    end
  end

  // unwritten entries read as zero
  always_comb begin
    for (int j = 0; j < brrc_pkg::MAX_RES; j++) begin
      claim_row[j] = claim_vq[j] ? claim_q[j] : '0;
      held_row[j]  = held_vq[j]  ? held_q[j]  : '0;
    end
  end

  // request check against need and free units
  always_comb begin
    for (int j = 0; j < brrc_pkg::MAX_RES; j++) begin
      need_over[j] = ({1'b0, req_buf[j]} + {1'b0, held_row[j]}) > {1'b0, claim_row[j]};
      free_over[j] = req_buf[j] > free_units[j];
    end
    bad_proc  = !(brrc_pkg::NP_W'(cmd.req_proc) < np);
    need_fail = |(need_over & res_mask);
    free_fail = |(free_over & res_mask);
    alloc_ok  = !bad_proc && !need_fail && !free_fail;
    if (bad_proc) begin
      chk_verdict = brrc_pkg::VERDICT_BAD_PROC;
    end else if (need_fail) begin
      chk_verdict = brrc_pkg::VERDICT_NEED;
    end else begin
      chk_verdict = brrc_pkg::VERDICT_FREE;
    end
  end

  // safety scan row test and saturating work update
  always_comb begin
    for (int j = 0; j < brrc_pkg::MAX_RES; j++) begin
      work_sum[j] = {1'b0, work[j]} + (brrc_pkg::WORK_W+1)'(held_row[j]);
      fit[j]      = (brrc_pkg::WORK_W+1)'(claim_row[j]) <= work_sum[j];
      work_sat[j] = work_sum[j][brrc_pkg::WORK_W] ? brrc_pkg::WORK_MAX
                                                   : work_sum[j][brrc_pkg::WORK_W-1:0];
    end
    row_ok = !finished[cmd.scan_row] && (&(fit | ~res_mask));
    safe   = &(finished | ~proc_mask);
  end

  assign stat.alloc_ok = alloc_ok;
  assign stat.row_ok   = row_ok;

  // held table write port: load, tentative allocation, rollback
  always_comb begin
    held_waddr = cmd.req_proc;
    held_we    = '0;
    held_wdata = saved_row;
    case (cmd.op)
      brrc_pkg::OP_LD_HELD: begin
        held_waddr = request.process;
        held_we[request.resource] = 1'b1;
        for (int j = 0; j < brrc_pkg::MAX_RES; j++) begin
          held_wdata[j] = request.amount;
        end
      end
      brrc_pkg::OP_CHECK: begin
        if (alloc_ok) begin
          held_we = res_mask;
          for (int j = 0; j < brrc_pkg::MAX_RES; j++) begin
            held_wdata[j] = held_row[j] + req_buf[j];
          end
        end
      end
      brrc_pkg::OP_FINISH: begin
        if (!safe) begin
          held_we = res_mask;
        end
      end
      default: begin
        held_we = '0;
      end
    endcase
  end

  // table storage and registered row reads
  always_ff @(posedge clk) begin
    for (int j = 0; j < brrc_pkg::MAX_RES; j++) begin
      if (cmd.op == brrc_pkg::OP_LD_CLAIM && request.resource == brrc_pkg::RES_W'(j)) begin
        claim_mem[request.process][j] <= request.amount;
      end
      if (held_we[j]) begin
        held_mem[held_waddr][j] <= held_wdata[j];
      end
    end
    claim_q <= claim_mem[cmd.rd_row];
    held_q  <= held_mem[cmd.rd_row];
  end

  // valid bits of the tables
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < brrc_pkg::MAX_PROCS; i++) begin
        claim_vld[i] <= '0;
        held_vld[i]  <= '0;
      end
      claim_vq <= '0;
      held_vq  <= '0;
    end else begin
      if (cmd.op == brrc_pkg::OP_LD_CLAIM) begin
        claim_vld[request.process][request.resource] <= 1'b1;
      end
      held_vld[held_waddr] <= held_vld[held_waddr] | held_we;
      claim_vq <= claim_vld[cmd.rd_row];
      held_vq  <= held_vld[cmd.rd_row];
    end
  end

  // keep the pre-allocation held row for rollback
  always_ff @(posedge clk) begin
    if (cmd.op == brrc_pkg::OP_CHECK) begin
      saved_row <= held_row;
    end
  end

  // free units, request buffer, work vector, finished flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < brrc_pkg::MAX_RES; j++) begin
        free_units[j] <= '0;
        req_buf[j]    <= '0;
        work[j]       <= '0;
      end
      finished <= '0;
    end else begin
      case (cmd.op)
        brrc_pkg::OP_LD_FREE: begin
          free_units[request.resource] <= request.amount;
        end
        brrc_pkg::OP_LD_REQ: begin
          req_buf[request.resource] <= request.amount;
        end
        brrc_pkg::OP_CHECK: begin
          if (alloc_ok) begin
            for (int j = 0; j < brrc_pkg::MAX_RES; j++) begin
              if (res_mask[j]) begin
                free_units[j] <= free_units[j] - req_buf[j];
              end
              work[j] <= brrc_pkg::WORK_W'(free_units[j] - req_buf[j]);
            end
            finished <= '0;
          end else begin
            for (int j = 0; j < brrc_pkg::MAX_RES; j++) begin
              req_buf[j] <= '0;
            end
          end
        end
        brrc_pkg::OP_SCAN_ROW: begin
          if (row_ok) begin
            for (int j = 0; j < brrc_pkg::MAX_RES; j++) begin
              if (res_mask[j]) begin
                work[j] <= work_sat[j];
              end
            end
            finished[cmd.scan_row] <= 1'b1;
          end
        end
        brrc_pkg::OP_FINISH: begin
          for (int j = 0; j < brrc_pkg::MAX_RES; j++) begin
            if (!safe && res_mask[j]) begin
              free_units[j] <= free_units[j] + req_buf[j];
            end
            req_buf[j] <= '0;
          end
        end
        default: begin
          finished <= finished;
        end
      endcase
    end
  end

  // drive the result strobe for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.op == brrc_pkg::OP_CHECK && !alloc_ok) ||
                      (cmd.op == brrc_pkg::OP_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    result.requester <= cmd.req_proc;
    if (cmd.op == brrc_pkg::OP_FINISH) begin
      result.verdict <= safe ? brrc_pkg::VERDICT_GRANTED : brrc_pkg::VERDICT_UNSAFE;
    end else begin
      result.verdict <= chk_verdict;
    end
  end

endmodule

@@ rtl/brrc_ctrl.sv @@
// ----------------------------------------------------------------------------
// brrc_ctrl
// Sequencer: decodes accepted requests, walks the check and the safety scan
// passes over the process rows, and issues datapath commands.
// ----------------------------------------------------------------------------
module brrc_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  brrc_pkg::request_t        request,
  input  logic [brrc_pkg::NP_W-1:0] np,
  input  brrc_pkg::dp_stat_t        stat,
  output brrc_pkg::dp_cmd_t         cmd,
  output logic                      busy
);

  brrc_pkg::ctl_state_t state;
  brrc_pkg::ctl_state_t state_next;
  logic [brrc_pkg::PROC_W-1:0] row;
  logic [brrc_pkg::PROC_W-1:0] row_next;
  logic [brrc_pkg::PROC_W-1:0] req_proc;
  logic [brrc_pkg::PROC_W-1:0] last_row;
  logic progress;
  logic progress_next;
  logic take;
  logic pass_end;

  assign take     = start && (state == brrc_pkg::ST_IDLE);
  assign last_row = brrc_pkg::PROC_W'(np - brrc_pkg::NP_W'(1));
  assign pass_end = (row == last_row);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      brrc_pkg::ST_IDLE: begin
        if (take && request.func == brrc_pkg::FUNC_REQ && request.last) begin
          state_next = brrc_pkg::ST_CHK_RD;
        end
      end
      brrc_pkg::ST_CHK_RD: begin
        state_next = brrc_pkg::ST_CHK;
      end
      brrc_pkg::ST_CHK: begin
        state_next = stat.alloc_ok ? brrc_pkg::ST_SCAN_START : brrc_pkg::ST_IDLE;
      end
      brrc_pkg::ST_SCAN_START: begin
        state_next = brrc_pkg::ST_SCAN;
      end
      brrc_pkg::ST_SCAN: begin
        if (pass_end && !(progress || stat.row_ok)) begin
          state_next = brrc_pkg::ST_FINISH;
        end
      end
      brrc_pkg::ST_FINISH: begin
        state_next = brrc_pkg::ST_IDLE;
      end
      default: begin
        state_next = brrc_pkg::ST_IDLE;
      end
    endcase
  end

  // row walk and pass progress
  always_comb begin
    row_next      = row;
    progress_next = progress;
    case (state)
      brrc_pkg::ST_SCAN_START: begin
        row_next      = '0;
        progress_next = 1'b0;
      end
      brrc_pkg::ST_SCAN: begin
        if (pass_end) begin
          row_next      = '0;
          progress_next = 1'b0;
        end else begin
          row_next      = row + brrc_pkg::PROC_W'(1);
          progress_next = progress || stat.row_ok;
        end
      end
      default: begin
        row_next = row;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd.op       = brrc_pkg::OP_NONE;
    cmd.rd_row   = req_proc;
    cmd.scan_row = row;
    cmd.req_proc = req_proc;
    busy         = (state != brrc_pkg::ST_IDLE);
    case (state)
      brrc_pkg::ST_IDLE: begin
        if (take) begin
          case (request.func)
            brrc_pkg::FUNC_LD_FREE:  cmd.op = brrc_pkg::OP_LD_FREE;
            brrc_pkg::FUNC_LD_CLAIM: cmd.op = brrc_pkg::OP_LD_CLAIM;
            brrc_pkg::FUNC_LD_HELD:  cmd.op = brrc_pkg::OP_LD_HELD;
            brrc_pkg::FUNC_REQ:      cmd.op = brrc_pkg::OP_LD_REQ;
            default:                 cmd.op = brrc_pkg::OP_NONE;
          endcase
        end
      end
      brrc_pkg::ST_CHK: begin
        cmd.op = brrc_pkg::OP_CHECK;
      end
      brrc_pkg::ST_SCAN_START: begin
        cmd.rd_row = row_next;
      end
      brrc_pkg::ST_SCAN: begin
        cmd.op     = brrc_pkg::OP_SCAN_ROW;
        cmd.rd_row = row_next;
      end
      brrc_pkg::ST_FINISH: begin
        cmd.op = brrc_pkg::OP_FINISH;
      end
      default: begin
        cmd.op = brrc_pkg::OP_NONE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= brrc_pkg::ST_IDLE;
      row      <= '0;
      progress <= 1'b0;
      req_proc <= '0;
    end else begin
      state    <= state_next;
      row      <= row_next;
      progress <= progress_next;
      if (take && request.func == brrc_pkg::FUNC_REQ && request.last) begin
        req_proc <= request.process;
      end
    end
  end

endmodule

@@ rtl/bankers_resource_request_check.sv @@
// ----------------------------------------------------------------------------
// bankers_resource_request_check
// Banker's deadlock avoidance unit: table loads, request check, safety scan.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge with start high and busy low. Loads of
// free units, max claim and held units, and request elements without the
// last mark, keep busy low. An element marked last raises busy: a denial for
// bad process, exceeding need or exceeding free units ends after the check;
// otherwise the safety scan follows, reading one process row of the claim and
// held tables per cycle, in 1 to N+1 passes over the N active process rows.
// The verdict shows on result with result_valid high for exactly one cycle,
// the first cycle after busy falls; it is not held, so the receiver must take
// it then. Configuration is to be written with cfg_we only while busy is low;
// the block itself does not enforce this.
`include "assert_macros.svh"

module bankers_resource_request_check (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  brrc_pkg::request_t              request,
  output logic                            busy,
  output brrc_pkg::result_t               result,
  output logic                            result_valid,
  input  logic                            cfg_we,
  input  logic [brrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [brrc_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [brrc_pkg::NP_W-1:0] np;
  logic [brrc_pkg::NR_W-1:0] nr;
  logic [brrc_pkg::NP_W-1:0] np_wr;
  logic [brrc_pkg::NR_W-1:0] nr_wr;
  brrc_pkg::dp_cmd_t  cmd;
  brrc_pkg::dp_stat_t stat;
  logic last_take;

  // clamp written counts to 1..max
  always_comb begin
    if (cfg_data == '0) begin
      np_wr = brrc_pkg::NP_W'(1);
    end else if (cfg_data > brrc_pkg::NP_W'(brrc_pkg::MAX_PROCS)) begin
      np_wr = brrc_pkg::NP_W'(brrc_pkg::MAX_PROCS);
    end else begin
      np_wr = cfg_data;
    end
    if (cfg_data[brrc_pkg::NR_W-1:0] == '0) begin
      nr_wr = brrc_pkg::NR_W'(1);
    end else if (cfg_data[brrc_pkg::NR_W-1:0] > brrc_pkg::NR_W'(brrc_pkg::MAX_RES)) begin
      nr_wr = brrc_pkg::NR_W'(brrc_pkg::MAX_RES);
    end else begin
      nr_wr = cfg_data[brrc_pkg::NR_W-1:0];
    end
  end

  // active counts
  always_ff @(posedge clk) begin
    if (rst) begin
      np <= brrc_pkg::NP_W'(brrc_pkg::MAX_PROCS);
      nr <= brrc_pkg::NR_W'(brrc_pkg::MAX_RES);
    end else if (cfg_we) begin
      case (cfg_index)
        brrc_pkg::CFG_PROCS:     np <= np_wr;
        brrc_pkg::CFG_RESOURCES: nr <= nr_wr;
        default:                 np <= np;
      endcase
    end
  end

  brrc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .np      (np),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  brrc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .request      (request),
    .np           (np),
    .nr           (nr),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid)
  );

  // final request element taken this cycle
  assign last_take = start && !busy && request.func == brrc_pkg::FUNC_REQ && request.last;

  // a verdict only appears once the sequencer is back to idle
  `ASSERT_IMPL(a_result_idle, clk, rst, result_valid, !busy, "result while busy")
  // a final request element always starts a check
  `ASSERT_NEXT(a_last_busy, clk, rst, last_take, busy, "last element did not start check")
  // verdicts are never back to back
  `ASSERT_NEXT(a_single_result, clk, rst, result_valid, !result_valid, "repeated result strobe")

endmodule

@@ tb/sv/brrc_checker.sv @@
// ----------------------------------------------------------------------------
// brrc_checker
// Watches the request, result and register channels of the banker's unit.
// Keeps its own copy of the free, claim and held tables, judges each final
// request element as it is taken, and compares the verdicts in order.
// ----------------------------------------------------------------------------
module brrc_checker
  import brrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  request_t              request,
  input  logic                  result_valid,
  input  result_t               result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    outstanding
);

  // shadow of the unit's tables and registers
  logic [AMT_W-1:0] avail [MAX_RES];
  logic [AMT_W-1:0] claim [MAX_PROCS][MAX_RES];
  logic [AMT_W-1:0] held  [MAX_PROCS][MAX_RES];
  logic [AMT_W-1:0] asked [MAX_RES];
  logic [NP_W-1:0]  procs_reg;
  logic [NR_W-1:0]  res_reg;

  result_t verdicts_due [$];
  result_t due;
  result_t fresh;
  int      mismatches;

  // zero acts as one, anything above the storage size saturates
  function automatic int clamp_count(int v, int top);
    if (v == 0) return 1;
    return (v > top) ? top : v;
  endfunction

  // banker's safety scan over the tentative tables
  function automatic bit system_safe(int np, int nr);
    logic [WORK_W-1:0]    work [MAX_RES];
    logic [MAX_PROCS-1:0] done;
    bit progress;
    bit fits;
    int sum;
    for (int j = 0; j < nr; j++) work[j] = WORK_W'(avail[j]);
    done = '0;
    progress = 1'b1;
    while (progress) begin
      progress = 1'b0;
      for (int i = 0; i < np; i++) begin
        if (!done[i]) begin
          fits = 1'b1;
          // a negative need never blocks a process
          for (int j = 0; j < nr; j++) begin
            if (int'(claim[i][j]) - int'(held[i][j]) > int'(work[j])) fits = 1'b0;
          end
          if (fits) begin
            for (int j = 0; j < nr; j++) begin
              sum = int'(work[j]) + int'(held[i][j]);
              work[j] = (sum > int'(WORK_MAX)) ? WORK_MAX : WORK_W'(sum);
            end
            done[i] = 1'b1;
            progress = 1'b1;
          end
        end
      end
    end
    for (int i = 0; i < np; i++) begin
      if (!done[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // judge the buffered request of process p; commit a grant, undo a denial
  function automatic verdict_t judge_request(int p);
    int np;
    int nr;
    np = clamp_count(procs_reg, MAX_PROCS);
    nr = clamp_count(res_reg, MAX_RES);
    if (p >= np) return VERDICT_BAD_PROC;
    for (int j = 0; j < nr; j++) begin
      if (int'(asked[j]) > int'(claim[p][j]) - int'(held[p][j])) return VERDICT_NEED;
    end
    for (int j = 0; j < nr; j++) begin
      if (asked[j] > avail[j]) return VERDICT_FREE;
    end
    for (int j = 0; j < nr; j++) begin
      avail[j]   = avail[j] - asked[j];
      held[p][j] = held[p][j] + asked[j];
    end
    if (system_safe(np, nr)) return VERDICT_GRANTED;
    for (int j = 0; j < nr; j++) begin
      avail[j]   = avail[j] + asked[j];
      held[p][j] = held[p][j] - asked[j];
    end
    return VERDICT_UNSAFE;
  endfunction

  task automatic note_failure(string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      // clear the shadow along with the unit
      for (int j = 0; j < MAX_RES; j++) begin
        avail[j] = '0;
        asked[j] = '0;
        for (int i = 0; i < MAX_PROCS; i++) begin
          claim[i][j] = '0;
          held[i][j]  = '0;
        end
      end
      procs_reg = NP_W'(MAX_PROCS);
      res_reg   = NR_W'(MAX_RES);
      verdicts_due.delete();
      mismatches = 0;
    end else begin
      // compare a verdict with the oldest one due
      if (result_valid) begin
        if (verdicts_due.size() == 0) begin
          note_failure($sformatf("verdict with none due: requester %0d verdict %0d",
                                 result.requester, result.verdict));
        end else begin
          due = verdicts_due.pop_front();
          if (result.requester !== due.requester)
            note_failure($sformatf("requester expected %0d, got %0d",
                                   due.requester, result.requester));
          if (result.verdict !== due.verdict)
            note_failure($sformatf("verdict for process %0d expected %0d (%s), got %0d",
                                   due.requester, due.verdict, due.verdict.name(),
                                   result.verdict));
        end
      end
      // track register writes
      if (cfg_we) begin
        if (cfg_index == CFG_PROCS) procs_reg = cfg_data[NP_W-1:0];
        else if (cfg_index == CFG_RESOURCES) res_reg = cfg_data[NR_W-1:0];
      end
      // apply an accepted request
      if (start && !busy) begin
        case (request.func)
          FUNC_LD_FREE:  avail[request.resource] = request.amount;
          FUNC_LD_CLAIM: claim[request.process][request.resource] = request.amount;
          FUNC_LD_HELD:  held[request.process][request.resource] = request.amount;
          FUNC_REQ: begin
            asked[request.resource] = request.amount;
            if (request.last) begin
              fresh.requester = request.process;
              fresh.verdict   = judge_request(int'(request.process));
              verdicts_due.push_back(fresh);
              for (int j = 0; j < MAX_RES; j++) asked[j] = '0;
            end
          end
          default: ;
        endcase
      end
    end
    errors      <= mismatches;
    outstanding <= verdicts_due.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives the banker's unit with table loads and multi-element requests:
// a directed opening over every verdict, then random phases under a range of
// process and resource counts, with random gaps and pauses on the sender.
// ----------------------------------------------------------------------------
module testbench;
  import brrc_pkg::*;

  localparam int ITEM_TARGET = 1750;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  request_t              request;
  logic                  busy;
  result_t               result;
  logic                  result_valid;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    outstanding;

  int sent;
  int live_procs;
  bit steady;
  int phase;
  int preset_procs [6] = '{1, 15, 8, 2, 9, 3};
  int preset_res   [6] = '{1, 7, 4, 8, 5, 2};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bankers_resource_request_check DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .request      (request),
    .busy         (busy),
    .result       (result),
    .result_valid (result_valid),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  brrc_checker verdict_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .outstanding  (outstanding)
  );

  function automatic request_t mk_item(func_t f, int p, int r, int amt, bit last);
    request_t item;
    item.func     = f;
    item.process  = PROC_W'(p);
    item.resource = RES_W'(r);
    item.amount   = AMT_W'(amt);
    item.last     = last;
    return item;
  endfunction

  // mostly small counts, now and then anything
  function automatic int pick_amount(int hi);
    return ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, hi);
  endfunction

  // hold off, then offer one request until the unit takes it
  task automatic send_req(request_t item);
    int gap;
    bit pause;
    gap   = steady ? 0 : $urandom_range(0, 6);
    pause = ($urandom_range(0, 49) == 0);
    if (gap > 0 || pause) start <= 1'b0;
    repeat (gap) @(posedge clk);
    if (pause) begin
      @(posedge clk);
      while (outstanding != 0) @(posedge clk);
    end
    start   <= 1'b1;
    request <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  // stop sending and let every due verdict arrive
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // write both count registers on back-to-back cycles
  task automatic set_config(int procs, int res);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PROCS;
    cfg_data  <= CFG_DATA_W'(procs);
    @(posedge clk);
    cfg_index <= CFG_RESOURCES;
    cfg_data  <= CFG_DATA_W'(res);
    @(posedge clk);
    cfg_we <= 1'b0;
    live_procs = (procs == 0) ? 1 : ((procs > MAX_PROCS) ? MAX_PROCS : procs);
  endtask

  // one random transaction: a request sequence, a table load or noise
  task automatic random_txn();
    int sel;
    int p;
    int n;
    int unsigned raw;
    bit tail;
    request_t noise;
    sel  = $urandom_range(0, 99);
    tail = 1'($urandom_range(0, 1));
    if (sel < 45) begin
      p = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_PROCS - 1)
                                      : $urandom_range(0, live_procs - 1);
      n = $urandom_range(1, MAX_RES);
      for (int k = 0; k < n; k++)
        send_req(mk_item(FUNC_REQ, p, $urandom_range(0, MAX_RES - 1), pick_amount(3),
                         k == n - 1));
    end else if (sel < 70) begin
      send_req(mk_item(FUNC_LD_CLAIM, $urandom_range(0, MAX_PROCS - 1),
                       $urandom_range(0, MAX_RES - 1), pick_amount(10), tail));
    end else if (sel < 85) begin
      send_req(mk_item(FUNC_LD_HELD, $urandom_range(0, MAX_PROCS - 1),
                       $urandom_range(0, MAX_RES - 1), pick_amount(6), tail));
    end else if (sel < 93) begin
      send_req(mk_item(FUNC_LD_FREE, $urandom_range(0, MAX_PROCS - 1),
                       $urandom_range(0, MAX_RES - 1), pick_amount(20), tail));
    end else begin
      raw   = $urandom;
      noise = request_t'(raw[$bits(request_t)-1:0]);
      send_req(noise);
    end
  endtask

  // end the run if it hangs
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    start      <= 1'b0;
    request    <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    rst        <= 1'b1;
    sent       = 0;
    steady     = 1'b0;
    phase      = 0;
    live_procs = MAX_PROCS;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // load free units at both extremes
    send_req(mk_item(FUNC_LD_FREE, 0, 0, 10, 1'b0));
    send_req(mk_item(FUNC_LD_FREE, 0, 1, 255, 1'b0));
    send_req(mk_item(FUNC_LD_FREE, 0, 2, 0, 1'b1));
    send_req(mk_item(FUNC_LD_FREE, 0, 3, 3, 1'b0));
    // grant, then exceed the remaining need
    send_req(mk_item(FUNC_LD_CLAIM, 0, 0, 8, 1'b0));
    send_req(mk_item(FUNC_LD_HELD, 0, 0, 2, 1'b0));
    send_req(mk_item(FUNC_REQ, 0, 0, 4, 1'b1));
    send_req(mk_item(FUNC_REQ, 0, 0, 3, 1'b1));
    // exceed free units
    send_req(mk_item(FUNC_LD_CLAIM, 1, 2, 7, 1'b0));
    send_req(mk_item(FUNC_REQ, 1, 2, 1, 1'b1));
    // two rivals on a scarce resource leave the system unsafe
    send_req(mk_item(FUNC_LD_CLAIM, 2, 3, 5, 1'b0));
    send_req(mk_item(FUNC_LD_CLAIM, 3, 3, 5, 1'b0));
    send_req(mk_item(FUNC_REQ, 2, 3, 2, 1'b1));
    // held above claim makes even a zero request exceed need
    send_req(mk_item(FUNC_LD_HELD, 4, 1, 9, 1'b0));
    send_req(mk_item(FUNC_REQ, 4, 0, 0, 1'b0));
    send_req(mk_item(FUNC_REQ, 4, 1, 0, 1'b1));
    // full-scale amounts on the top process
    send_req(mk_item(FUNC_REQ, 7, 3, 255, 1'b1));
    send_req(mk_item(FUNC_LD_CLAIM, 7, 1, 255, 1'b0));
    send_req(mk_item(FUNC_LD_HELD, 7, 1, 255, 1'b0));
    send_req(mk_item(FUNC_REQ, 7, 1, 0, 1'b1));
    drain();

    // zero counts act as one: bad process, resources beyond the active count
    set_config(0, 0);
    send_req(mk_item(FUNC_REQ, 1, 0, 0, 1'b1));
    send_req(mk_item(FUNC_LD_FREE, 0, 2, 200, 1'b0));
    send_req(mk_item(FUNC_REQ, 0, 2, 50, 1'b0));
    send_req(mk_item(FUNC_REQ, 0, 0, 1, 1'b1));
    drain();

    // random phases, each under its own register setting
    while (sent < ITEM_TARGET) begin
      if (phase < 6) set_config(preset_procs[phase], preset_res[phase]);
      else set_config($urandom_range(0, 15), $urandom_range(0, 15));
      phase++;
      steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(60, 160)) random_txn();
      drain();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
